[src/sts_pkg.sv]
// Shared types, constants and the sigmoid table for the target steering block.
package sts_pkg;

  // Sigmoid table geometry
  localparam int SIG_DEPTH = 256;
  localparam int IDX_W     = $clog2(SIG_DEPTH);
  // Q16 quotient |n|*2^16/d: |n| < 512, d >= 5
  localparam int MAG_W     = 9;
  localparam int A_W       = 23;
  localparam int P_W       = A_W + IDX_W;
  localparam int I_W       = P_W - 16;
  localparam int RECIP_W   = 30;
  localparam int DIV_W     = 7;
  // register stages inside one sigmoid unit
  localparam int SIG_LAT   = 5;

  // Table step 8/DEPTH in Q32
  localparam logic [63:0] SIG_STEP = (64'd8 << 32) / 64'(SIG_DEPTH);

  // Divisor select codes
  localparam logic [1:0] DIV_Y     = 2'd0;  // 20
  localparam logic [1:0] DIV_NEAR  = 2'd1;  // 5
  localparam logic [1:0] DIV_FAR   = 2'd2;  // 15
  localparam logic [1:0] DIV_STEER = 2'd3;  // 100

  // Detection kinds
  localparam logic [1:0] OP_BLOCK  = 2'd0;
  localparam logic [1:0] OP_ARROW  = 2'd1;
  localparam logic [1:0] OP_NONE   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Q0.9 weights
  localparam logic [8:0] W_HEAVY = 9'd307;
  localparam logic [8:0] W_LIGHT = 9'd205;

  localparam logic [16:0] Q16_ONE = 17'h10000;
  localparam logic [6:0]  SPEED_MAX = 7'd100;

  typedef struct packed {
    logic [1:0] opcode;
    logic [8:0] box_x_center;
    logic [7:0] box_y_center;
    logic [8:0] box_width;
    logic [7:0] box_height;
    logic [8:0] arrow_x_origin;
    logic [8:0] arrow_x_target;
  } det_t;

  typedef struct packed {
    logic       drive_forward;
    logic [6:0] left_speed;
    logic [6:0] right_speed;
  } cmd_t;

  // Sideband that follows an item through the sigmoid stages
  typedef struct packed {
    logic drive;
    logic arrow;
    logic incl;
    logic e_pos;
    logic e_neg;
  } side_t;

  typedef logic [15:0] sig_tab_t [SIG_DEPTH+1];

  function automatic logic [DIV_W-1:0] div_value(input logic [1:0] sel);
    logic [DIV_W-1:0] d;
    unique case (sel)
      DIV_Y:     d = 7'd20;
      DIV_NEAR:  d = 7'd5;
      DIV_FAR:   d = 7'd15;
      DIV_STEER: d = 7'd100;
      default:   d = 7'd100;
    endcase
    return d;
  endfunction

  // floor(2^32 / d)
  function automatic logic [RECIP_W-1:0] div_recip(input logic [1:0] sel);
    logic [RECIP_W-1:0] m;
    unique case (sel)
      DIV_Y:     m = 30'd214748364;
      DIV_NEAR:  m = 30'd858993459;
      DIV_FAR:   m = 30'd286331153;
      DIV_STEER: m = 30'd42949672;
      default:   m = 30'd42949672;
    endcase
    return m;
  endfunction

  // Restoring shift-subtract quotient, used only while building the table
  function automatic logic [63:0] quot64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Logistic table over [0,8], integer exp series, evaluated at elaboration
  function automatic sig_tab_t build_sig_table();
    logic [63:0] s;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] v;
    sig_tab_t    t;
    s    = SIG_STEP;
    term = 64'd1 << 32;
    sum  = term;
    for (int k = 1; k <= 12; k++) begin
      term = quot64((term * s) >> 32, 64'(k));
      sum  = sum + term;
    end
    r = quot64(64'hFFFF_FFFF_FFFF_FFFF, sum);
    e = 64'd1 << 32;
    for (int k = 0; k <= SIG_DEPTH; k++) begin
      if (k > 0) e = (e * r) >> 32;
      den = (64'd1 << 32) + e;
      v   = quot64((64'd1 << 48) + (den >> 1), den);
      t[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

[src/sts_sigmoid.sv]
// Five-stage Q0.16 sigmoid of +/- mag/d: reciprocal divide, table lookup, interpolation.
module sts_sigmoid (
  input  logic                      clk,
  input  logic                      en,
  input  logic [sts_pkg::MAG_W-1:0] mag,
  input  logic [1:0]                dsel,
  input  logic                      neg,
  output logic [16:0]               sig
);
  import sts_pkg::*;

  // stage A: x * floor(2^32/d)
  logic [MAG_W+RECIP_W-1:0] prod1;
  logic [MAG_W-1:0]         xa;
  logic [DIV_W-1:0]         da;
  logic                     na;
  // stage B: q0 * d
  logic [A_W-1:0]           q0;
  logic [A_W+DIV_W-1:0]     prod2;
  logic [MAG_W-1:0]         xb;
  logic [DIV_W-1:0]         db;
  logic                     nb;
  // stage C: table reads
  logic [15:0]              lo;
  logic [15:0]              hi;
  logic [15:0]              fc;
  logic                     nc;
  // stage D: interpolation product
  logic [31:0]              prod3;
  logic [15:0]              lod;
  logic                     nd;

  logic [MAG_W+15:0]        num;
  logic [MAG_W+15:0]        rem;
  logic [A_W-1:0]           a;
  logic [P_W-1:0]           p;
  logic [I_W-1:0]           idx;
  logic                     sat;
  logic [IDX_W-1:0]         ip;
  logic [IDX_W:0]           ip1;
  logic [15:0]              diff;
  logic [16:0]              v;

  function automatic logic [MAG_W+RECIP_W-1:0] xa_in_mul(input logic [MAG_W-1:0] x,
                                                         input logic [1:0] s);
    return (MAG_W+RECIP_W)'(x) * (MAG_W+RECIP_W)'(div_recip(s));
  endfunction

  // quotient correction and lookup address
  always_comb begin
    num = {xb, 16'd0};
    rem = num - prod2[MAG_W+15:0];
    a   = (rem >= (MAG_W+16)'(db)) ? q0 + A_W'(1) : q0;
    p   = {a, IDX_W'(0)} >> 3;
    idx = p[P_W-1:16];
    sat = idx >= I_W'(SIG_DEPTH);
    ip  = idx[IDX_W-1:0];
    ip1 = {1'b0, ip} + (IDX_W+1)'(1);
    diff = (hi > lo) ? hi - lo : 16'd0;
    v    = {1'b0, lod} + {1'b0, prod3[31:16]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1 <= xa_in_mul(mag, dsel);
      xa    <= mag;
      da    <= div_value(dsel);
      na    <= neg;

      q0    <= prod1[MAG_W+RECIP_W-1:16];
      prod2 <= (A_W+DIV_W)'(prod1[MAG_W+RECIP_W-1:16]) * (A_W+DIV_W)'(da);
      xb    <= xa;
      db    <= da;
      nb    <= na;

      lo    <= sat ? SIG_TABLE[SIG_DEPTH] : SIG_TABLE[ip];
      hi    <= sat ? SIG_TABLE[SIG_DEPTH] : SIG_TABLE[ip1];
      fc    <= p[15:0];
      nc    <= nb;

      prod3 <= diff * fc;
      lod   <= lo;
      nd    <= nc;

      sig   <= nd ? Q16_ONE - v : v;
    end
  end

endmodule

[src/sigmoid_target_steering_top.sv]
// Top level: detection decode, three sigmoid units, intensity blend and motor speeds.
// Path: stage 1 decode register, the sigmoid units, the blend and split register, the intensity product register, cmd.
// Throughput: one detection per cycle; the whole pipeline holds while a valid cmd is stalled.
// Each sigmoid unit (reciprocal divide, table lookup, interpolation) spans 5 stages.
// Reset (rst, synchronous) empties the pipeline and sets camera_inclined to 1.
module sigmoid_target_steering_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          det_valid,
  output logic          det_stall,
  input  sts_pkg::det_t det,
  output logic          cmd_valid,
  input  logic          cmd_stall,
  output sts_pkg::cmd_t cmd,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);
  import sts_pkg::*;

  logic advance;
  logic camera_inclined;

  // stage 1 registers
  logic                 v1;
  side_t                side1;
  logic [MAG_W-1:0]     mag_y;
  logic                 neg_y;
  logic [MAG_W-1:0]     mag_m;
  logic                 neg_m;
  logic [1:0]           sel_m;
  logic [MAG_W-1:0]     mag_e;

  // sideband delay over the sigmoid units
  logic                 vs   [SIG_LAT];
  side_t                sides[SIG_LAT];
  logic [16:0]          s_y;
  logic [16:0]          s_m;
  logic [16:0]          s_e;

  // stage 7
  logic                 v7;
  side_t                side7;
  logic [25:0]          py;
  logic [25:0]          pm;
  logic [16:0]          sl7;
  logic [16:0]          sr7;
  // stage 8
  logic                 v8;
  logic                 drive8;
  logic [33:0]          pl;
  logic [33:0]          pr;

  // combinational terms: stage 1 decode, blend, intensity and speed products
  logic signed [9:0]    ny;
  logic [9:0]           wh;
  logic signed [9:0]    nm;
  logic signed [10:0]   ne;
  logic [26:0]          blend;
  logic [16:0]          inten;
  logic [40:0]          spl;
  logic [40:0]          spr;

  assign advance   = !(cmd_valid && cmd_stall);
  assign det_stall = !advance;

  always_comb begin
    ny = 10'sd120 - $signed({2'b00, det.box_y_center});
    wh = {1'b0, det.box_width} + {2'b00, det.box_height};
    nm = 10'sd70 - $signed({1'b0, wh[9:1]});
    if (det.opcode == OP_ARROW) begin
      ne = $signed({2'b00, det.arrow_x_origin}) - $signed({2'b00, det.arrow_x_target});
    end else begin
      ne = 11'sd160 - $signed({2'b00, det.box_x_center});
    end
    blend = 27'(py) + 27'(pm);
    inten = side7.arrow ? Q16_ONE : blend[25:9];
    spl   = 41'(pl) * 41'(SPEED_MAX);
    spr   = 41'(pr) * 41'(SPEED_MAX);
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_inclined <= 1'b1;
    end else if (cfg_we) begin
      camera_inclined <= cfg_wdata;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v7        <= 1'b0;
      v8        <= 1'b0;
      cmd_valid <= 1'b0;
      for (int k = 0; k < SIG_LAT; k++) vs[k] <= 1'b0;
    end else if (advance) begin
      v1 <= det_valid;
      vs[0] <= v1;
      for (int k = 1; k < SIG_LAT; k++) vs[k] <= vs[k-1];
      v7        <= vs[SIG_LAT-1];
      v8        <= v7;
      cmd_valid <= v8;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance) begin
      side1.drive <= (det.opcode == OP_BLOCK) || (det.opcode == OP_ARROW);
      side1.arrow <= det.opcode == OP_ARROW;
      side1.incl  <= camera_inclined;
      side1.e_pos <= ne > 11'sd0;
      side1.e_neg <= ne < 11'sd0;
      mag_y <= ny[9] ? MAG_W'(-ny) : MAG_W'(ny);
      neg_y <= ny[9];
      mag_m <= nm[9] ? MAG_W'(-nm) : MAG_W'(nm);
      neg_m <= nm[9];
      sel_m <= (nm > 10'sd0) ? DIV_NEAR : DIV_FAR;
      mag_e <= ne[10] ? MAG_W'(-ne) : MAG_W'(ne);

      sides[0] <= side1;
      for (int k = 1; k < SIG_LAT; k++) sides[k] <= sides[k-1];

      // blend weights and steering split
      side7 <= sides[SIG_LAT-1];
      py  <= 26'(sides[SIG_LAT-1].incl ? W_HEAVY : W_LIGHT) * 26'(s_y);
      pm  <= 26'(sides[SIG_LAT-1].incl ? W_LIGHT : W_HEAVY) * 26'(s_m);
      sl7 <= sides[SIG_LAT-1].e_pos ? Q16_ONE - s_e : s_e;
      sr7 <= sides[SIG_LAT-1].e_neg ? Q16_ONE - s_e : s_e;

      // intensity times split
      drive8 <= side7.drive;
      pl <= 34'(sl7) * 34'(inten);
      pr <= 34'(sr7) * 34'(inten);

      // scale to percent and saturate; zero speeds when not driving
      cmd.drive_forward <= drive8;
      if (!drive8) begin
        cmd.left_speed  <= 7'd0;
        cmd.right_speed <= 7'd0;
      end else begin
        cmd.left_speed  <= (spl[40:32] > 9'(SPEED_MAX)) ? SPEED_MAX : spl[38:32];
        cmd.right_speed <= (spr[40:32] > 9'(SPEED_MAX)) ? SPEED_MAX : spr[38:32];
      end
    end
  end

  sts_sigmoid u_sig_y (
    .clk  (clk),
    .en   (advance),
    .mag  (mag_y),
    .dsel (DIV_Y),
    .neg  (neg_y),
    .sig  (s_y)
  );

  sts_sigmoid u_sig_m (
    .clk  (clk),
    .en   (advance),
    .mag  (mag_m),
    .dsel (sel_m),
    .neg  (neg_m),
    .sig  (s_m)
  );

  sts_sigmoid u_sig_e (
    .clk  (clk),
    .en   (advance),
    .mag  (mag_e),
    .dsel (DIV_STEER),
    .neg  (1'b0),
    .sig  (s_e)
  );

endmodule

[tb/sts_checker.sv]
// Checker for the target steering block: predicts motor commands and compares them.
`timescale 1ns / 100ps

module sts_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          det_valid,
  input  logic          det_stall,
  input  sts_pkg::det_t det,
  input  logic          cmd_valid,
  input  logic          cmd_stall,
  input  sts_pkg::cmd_t cmd,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  output int            fail_count,
  output int            pending
);
  import sts_pkg::*;

  logic [15:0]   logistic [SIG_DEPTH+1];
  logic          incl_mode;
  cmd_t          cmd_expected [$];

  // Logistic table, built with the same integer exp series
  initial begin
    logic [63:0] s, term, sum, r, e, den, v;
    s = (64'd8 << 32) / 64'(SIG_DEPTH);
    term = 64'd1 << 32;
    sum = term;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * s) >> 32) / 64'(k);
      sum = sum + term;
    end
    r = 64'hFFFF_FFFF_FFFF_FFFF / sum;
    e = 64'd1 << 32;
    for (int k = 0; k <= SIG_DEPTH; k++) begin
      if (k > 0) e = (e * r) >> 32;
      den = (64'd1 << 32) + e;
      v = ((64'd1 << 48) + den / 2) / den;
      logistic[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
    end
  end

  // Q0.16 logistic of n/d with linear interpolation
  function automatic logic [16:0] logistic_q16(input int n, input int d);
    longint unsigned mag, a, p, idx, frac;
    longint unsigned lo, hi, diff, v;
    mag = (n < 0) ? -n : n;
    a = (mag << 16) / d;
    p = (a * SIG_DEPTH) >> 3;
    idx = p >> 16;
    frac = p & 64'hFFFF;
    if (idx >= SIG_DEPTH) v = logistic[SIG_DEPTH];
    else begin
      lo = logistic[idx];
      hi = logistic[idx+1];
      diff = (hi > lo) ? hi - lo : 0;
      v = lo + ((diff * frac) >> 16);
    end
    return (n < 0) ? 17'(65536 - v) : 17'(v);
  endfunction

  function automatic logic [6:0] motor_power(input longint unsigned s,
                                             input longint unsigned inten);
    longint unsigned v;
    v = (100 * s * inten) >> 32;
    return (v > 100) ? 7'd100 : 7'(v);
  endfunction

  function automatic cmd_t steer_command(input det_t d, input logic incl);
    cmd_t c;
    int err, m;
    longint unsigned inten, s1, s2, wy, ws;
    c = '0;
    if (d.opcode == OP_BLOCK) begin
      m = 70 - (int'(d.box_width) + int'(d.box_height)) / 2;
      s1 = logistic_q16(120 - int'(d.box_y_center), 20);
      s2 = (m > 0) ? logistic_q16(m, 5) : logistic_q16(m, 15);
      wy = incl ? 307 : 205;
      ws = incl ? 205 : 307;
      inten = (wy * s1 + ws * s2) >> 9;
      err = 160 - int'(d.box_x_center);
    end else if (d.opcode == OP_ARROW) begin
      inten = 65536;
      err = int'(d.arrow_x_origin) - int'(d.arrow_x_target);
    end else return c;
    c.drive_forward = 1'b1;
    c.left_speed = motor_power(logistic_q16(-err, 100), inten);
    c.right_speed = motor_power(logistic_q16(err, 100), inten);
    return c;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = cmd_expected.size();

  // Track config, predict on detections, compare on commands
  always @(posedge clk) begin
    cmd_t want;
    if (rst) begin
      incl_mode <= 1'b1;
      cmd_expected.delete();
    end else begin
      if (cfg_we) incl_mode <= cfg_wdata;
      if (det_valid && !det_stall) cmd_expected.push_back(steer_command(det, incl_mode));
      if (cmd_valid && !cmd_stall) begin
        if (cmd_expected.size() == 0) report_mismatch("unexpected transaction", 1, 0);
        else begin
          want = cmd_expected.pop_front();
          if (cmd.drive_forward !== want.drive_forward)
            report_mismatch("drive_forward", cmd.drive_forward, want.drive_forward);
          if (cmd.left_speed !== want.left_speed)
            report_mismatch("left_speed", cmd.left_speed, want.left_speed);
          if (cmd.right_speed !== want.right_speed)
            report_mismatch("right_speed", cmd.right_speed, want.right_speed);
        end
      end
    end
  end

  initial fail_count = 0;
endmodule

[tb/tb_sigmoid_target_steering_top.sv]
// Testbench top: detection stimulus, config phases, command stalls and verdict.
`timescale 1ns / 100ps

module tb_sigmoid_target_steering_top;
  import sts_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic det_valid = 1'b0;
  logic det_stall;
  det_t det = '0;
  logic cmd_valid;
  logic cmd_stall = 1'b0;
  cmd_t cmd;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  int   fail_count;
  int   pending;
  logic long_hold = 1'b0;

  always #1 clk = ~clk;

  sigmoid_target_steering_top uut (
    .clk(clk), .rst(rst),
    .det_valid(det_valid), .det_stall(det_stall), .det(det),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  sts_checker chk (
    .clk(clk), .rst(rst),
    .det_valid(det_valid), .det_stall(det_stall), .det(det),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // Offer one transaction and hold it until accepted; valid stays up for the next one
  task automatic send_detection(input det_t d);
    int gap;
    gap = short_gap();
    if (gap > 0) begin
      det_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    det <= d;
    det_valid <= 1'b1;
    do @(posedge clk); while (det_stall);
    @(negedge clk);
  endtask

  function automatic det_t random_detection();
    det_t        d;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    d = raw[$bits(det_t)-1:0];
    case ($urandom_range(0, 9))
      0: d.opcode = OP_NONE;
      1: d.opcode = OP_UNUSED;
      2, 3, 4: d.opcode = OP_ARROW;
      default: d.opcode = OP_BLOCK;
    endcase
    // mostly in-range pixels; raw field bits the rest of the time
    if ($urandom_range(0, 3) != 0) begin
      d.box_x_center = 9'($urandom_range(0, 320));
      d.box_y_center = 8'($urandom_range(0, 240));
      d.box_width = 9'($urandom_range(0, 320));
      d.box_height = 8'($urandom_range(0, 240));
      d.arrow_x_origin = 9'($urandom_range(0, 320));
      d.arrow_x_target = 9'($urandom_range(0, 320));
    end
    return d;
  endfunction

  task automatic set_mode(input logic incl);
    det_valid <= 1'b0;
    wait (pending == 0);
    repeat (12) @(negedge clk);
    cfg_wdata <= incl;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Receiver stalls: random gaps, plus one long hold on request
  initial begin
    int hold;
    @(negedge clk);
    forever begin
      if (long_hold) begin
        cmd_stall <= 1'b1;
        for (hold = 0; hold < 60; hold++) @(negedge clk);
        cmd_stall <= 1'b0;
        wait (!long_hold);
        @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        cmd_stall <= 1'b1;
        repeat (short_gap() + 1) @(negedge clk);
        cmd_stall <= 1'b0;
        @(negedge clk);
      end else if ($urandom_range(0, 5) == 0) begin
        repeat (40) @(negedge clk);
      end else @(negedge clk);
    end
  end

  // Main stimulus
  initial begin
    det_t d;
    int waited;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed corners
    d = '0;
    d.opcode = OP_NONE;
    send_detection(d);
    d.opcode = OP_UNUSED;
    send_detection(d);
    d = '1;
    d.opcode = OP_BLOCK;
    send_detection(d);
    d = '0;
    send_detection(d);
    d.box_x_center = 160; d.box_y_center = 120; d.box_width = 70; d.box_height = 70;
    send_detection(d);
    d.box_width = 71; d.box_height = 70;  // m = 0 takes the far slope
    send_detection(d);
    d.box_width = 68; d.box_height = 70;  // m = 1 takes the near slope
    send_detection(d);
    d.box_x_center = 320; d.box_y_center = 240; d.box_width = 320; d.box_height = 240;
    send_detection(d);
    d.box_x_center = 0; d.box_y_center = 0; d.box_width = 0; d.box_height = 0;
    send_detection(d);
    d = '0;
    d.opcode = OP_ARROW;
    send_detection(d);
    d.arrow_x_origin = 320; d.arrow_x_target = 0;
    send_detection(d);
    d.arrow_x_origin = 0; d.arrow_x_target = 320;
    send_detection(d);
    d.arrow_x_origin = 9'h1FF; d.arrow_x_target = 0;
    send_detection(d);
    d.arrow_x_origin = 0; d.arrow_x_target = 9'h1FF;
    send_detection(d);

    // Mode phases, each mode twice, random detections in each, one long receiver hold
    for (int ph = 0; ph < 4; ph++) begin
      set_mode(ph[0]);
      for (int n = 0; n < 150; n++) begin
        if (ph == 1 && n == 20) long_hold <= 1'b1;
        if (ph == 1 && n == 70) long_hold <= 1'b0;
        send_detection(random_detection());
      end
    end
    det_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end
endmodule

[filelist.f]
src/sts_pkg.sv
src/sts_sigmoid.sv
src/sigmoid_target_steering_top.sv
tb/sts_checker.sv
tb/tb_sigmoid_target_steering_top.sv
